### rtl/rgbe_pkg.sv
// shared types, constants and colour helpers for the rgb led spi bit encoder
package rgbe_pkg;

  // chain limit built into the block
  localparam int unsigned MAX_LEDS = 1024;
  localparam logic [15:0] MaxLedsW = 16'(MAX_LEDS);

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // colour bits per pixel, sent msb first
  localparam int unsigned COLOR_BITS = 24;
  localparam logic [4:0] LastBit = 5'(COLOR_BITS - 1);

  // colour source selector codes
  localparam logic [1:0] FUNC_PACKED = 2'd0;
  localparam logic [1:0] FUNC_LEVELS = 2'd1;
  localparam logic [1:0] FUNC_WHEEL  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ONE_CODE    = 2'd0;
  localparam logic [1:0] CFG_ZERO_CODE   = 2'd1;
  localparam logic [1:0] CFG_PIXEL_COUNT = 2'd2;

  // configuration register reset values
  localparam logic [7:0]  OneCodeRst    = 8'd248;
  localparam logic [7:0]  ZeroCodeRst   = 8'd192;
  localparam logic [10:0] PixelCountRst = 11'd1024;

  // one pixel request word
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] led_index;
    logic [23:0] packed_grb;
    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
    logic [7:0]  wheel_position;
  } rgbe_in_t;

  // one encoded spi byte word
  typedef struct packed {
    logic [7:0] spi_byte;
    logic [4:0] bit_number;
    logic [9:0] led_echo;
    logic       last_byte;
  } rgbe_out_t;

  // classified pixel waiting for serialization
  typedef struct packed {
    logic [23:0] color;
    logic [9:0]  led;
  } rgbe_entry_t;

  // configuration register set
  typedef struct packed {
    logic [7:0]  one_code;
    logic [7:0]  zero_code;
    logic [10:0] pixel_count;
  } rgbe_cfg_t;

  // pack separate levels as green, red, blue
  function automatic logic [23:0] pack_grb(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    return {g, r, b};
  endfunction

  // rainbow wheel: three segments of 85, 85 and 86 positions with steps of 3
  function automatic logic [23:0] wheel_color(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] q3;
    logic [23:0] res;
    p = ~pos;
    if (p < 8'd85) begin
      q = p;
    end else if (p < 8'd170) begin
      q = p - 8'd85;
    end else begin
      q = p - 8'd170;
    end
    q3 = 8'({1'b0, q, 1'b0} + {2'b00, q});
    if (p < 8'd85) begin
      res = pack_grb(8'd255 - q3, 8'd0, q3);
    end else if (p < 8'd170) begin
      res = pack_grb(8'd0, q3, 8'd255 - q3);
    end else begin
      res = pack_grb(q3, 8'd255 - q3, 8'd0);
    end
    return res;
  endfunction

endpackage

### rtl/rgbe_front.sv
// front end: range check, colour source selection and colour packing
module rgbe_front (
  input  rgbe_pkg::rgbe_in_t    in_data_i,
  input  logic [10:0]           pixel_count_i,
  output logic                  keep_o,
  output rgbe_pkg::rgbe_entry_t entry_o
);
  import rgbe_pkg::*;

  logic       in_range;
  logic       func_ok;
  logic [23:0] color;

  // index must sit below both the programmed count and the built-in limit
  assign in_range = (in_data_i.led_index < {5'b0, pixel_count_i}) &&
                    (in_data_i.led_index < MaxLedsW);

  // colour source select
  always_comb begin
    func_ok = 1'b1;
    color   = in_data_i.packed_grb;
    unique case (in_data_i.func)
      FUNC_PACKED: color = in_data_i.packed_grb;
      FUNC_LEVELS: color = pack_grb(in_data_i.red_level, in_data_i.green_level,
                                    in_data_i.blue_level);
      FUNC_WHEEL:  color = wheel_color(in_data_i.wheel_position);
      default:     func_ok = 1'b0;
    endcase
  end

  assign keep_o        = in_range && func_ok;
  assign entry_o.color = color;
  assign entry_o.led   = in_data_i.led_index[9:0];

endmodule

### rtl/rgbe_queue.sv
// small fifo of classified pixels between front and back
module rgbe_queue #(
  parameter int unsigned Depth = rgbe_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  rgbe_pkg::rgbe_entry_t wr_data_i,
  input  logic                  rd_en_i,
  output rgbe_pkg::rgbe_entry_t rd_data_o,
  output logic                  full_o,
  output logic                  empty_o
);
  import rgbe_pkg::*;

  // depth must be at least 2
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  rgbe_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o    = (cnt_q == CntFull);
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### rtl/rgbe_back.sv
// back end: serializes one pixel into 24 spi bytes through an output register
module rgbe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rgbe_pkg::rgbe_cfg_t   cfg_i,
  input  logic                  q_empty_i,
  input  rgbe_pkg::rgbe_entry_t q_data_i,
  output logic                  q_pop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output rgbe_pkg::rgbe_out_t   out_data_o
);
  import rgbe_pkg::*;

  logic        active_q, active_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [23:0] shift_q;
  logic [9:0]  echo_q;
  rgbe_out_t   out_q;
  logic        step;
  logic        last;
  logic        load;

  // step emits one byte, load pulls the next pixel with no bubble
  assign step    = active_q && (!out_valid_q || pop_i);
  assign last    = (cnt_q == LastBit);
  assign load    = (!active_q || (step && last)) && !q_empty_i;
  assign q_pop_o = load;

  always_comb begin
    active_d    = active_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (load) begin
      active_d = 1'b1;
      cnt_d    = '0;
    end else if (step) begin
      active_d = !last;
      cnt_d    = cnt_q + 1'b1;
    end
    if (step) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // colour shift register and output word
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.spi_byte   <= shift_q[23] ? cfg_i.one_code : cfg_i.zero_code;
      out_q.bit_number <= cnt_q;
      out_q.led_echo   <= echo_q;
      out_q.last_byte  <= last;
    end
    if (load) begin
      shift_q <= q_data_i.color;
      echo_q  <= q_data_i.led;
    end else if (step) begin
      shift_q <= {shift_q[22:0], 1'b0};
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_data_o = out_q;

`ifndef SYNTHESIS
  a_last_is_bit23 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.last_byte |-> out_q.bit_number == LastBit)
    else $error("last byte flagged on wrong bit");
  a_pop_needs_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_empty_i)
    else $error("queue read while empty");
  a_pixel_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !last |=> active_q)
    else $error("pixel serialization stopped early");
  a_step_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("emitted byte lost");
`endif

endmodule

### rtl/rgb_led_spi_bit_encoder.sv
// top level: config registers, front end, pixel queue and byte serializer
// Each accepted pixel request becomes 24 spi bytes, msb of the green-red-blue
// colour first, one byte per clock while pop keeps up, so a stream of pixels
// is paced by the single-byte result port. Requests are taken every cycle
// while the pixel queue (QueueDepth entries) has room; requests with an
// out-of-range index or an unused func code are taken and dropped. The first
// byte of a pixel passes the queue storage, the shift register and the output
// register before it is on the result port. Configuration writes are taken at
// once and should only be issued while no pixel is in flight.
module rgb_led_spi_bit_encoder #(
  parameter int unsigned QueueDepth = rgbe_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  rgbe_pkg::rgbe_in_t  in_data_i,
  output logic                empty,
  input  logic                pop,
  output rgbe_pkg::rgbe_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [10:0]         cfg_data_i
);
  import rgbe_pkg::*;

  rgbe_cfg_t   cfg_q, cfg_d;
  logic        keep;
  rgbe_entry_t entry;
  logic        q_wr;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  rgbe_entry_t q_data;

  // configuration register writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ONE_CODE:    cfg_d.one_code    = cfg_data_i[7:0];
        CFG_ZERO_CODE:   cfg_d.zero_code   = cfg_data_i[7:0];
        CFG_PIXEL_COUNT: cfg_d.pixel_count = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_code    <= OneCodeRst;
      cfg_q.zero_code   <= ZeroCodeRst;
      cfg_q.pixel_count <= PixelCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rgbe_front u_front (
    .in_data_i     (in_data_i),
    .pixel_count_i (cfg_q.pixel_count),
    .keep_o        (keep),
    .entry_o       (entry)
  );

  // only valid pixels enter the queue
  assign full = q_full;
  assign q_wr = push && !q_full && keep;

  rgbe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_wr),
    .wr_data_i (entry),
    .rd_en_i   (q_pop),
    .rd_data_o (q_data),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  rgbe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_data_o (out_data_o)
  );

endmodule
